@@ hw/rtl/bce_pkg.sv @@
// Shared types and constants for the braille chord key encoder.
// Used by the channel interfaces, the register block and the top level.
`default_nettype none

package bce_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int NUM_KEYS   = 8;
    localparam int KEY_W      = 3;
    localparam int CHORD_W    = 6;
    localparam int NOW_W      = 32;
    localparam int LOCKOUT_W  = 16;
    localparam int MASK_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KEY_W-1:0]     KEY_DELETE    = 3'd6;
    localparam logic [KEY_W-1:0]     KEY_ENTER     = 3'd7;
    localparam logic [BYTE_W-1:0]    BYTE_NEWLINE  = 8'h40;
    localparam logic [BYTE_W-1:0]    BYTE_ERASE    = 8'h80;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd200;
    localparam logic [MASK_W-1:0]    ENABLE_RESET  = 8'd60;

    typedef enum logic [0:0] {
        MODE_KEY   = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DISABLED  = 3'd0,
        ST_BOUNCED   = 3'd1,
        ST_TOGGLED   = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_ERASE     = 3'd4,
        ST_CHAR      = 3'd5,
        ST_NEWLINE   = 3'd6,
        ST_CMD_CLEAR = 3'd7
    } status_t;

    typedef enum logic [0:0] {
        REG_LOCKOUT = 1'b0,
        REG_ENABLE  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [LOCKOUT_W-1:0] lockout_ms;
        logic [MASK_W-1:0]    key_enable_mask;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/bce_if.sv @@
// Valid/ready channel interfaces for key events and encoder results.
// Depends on bce_pkg for field widths.
`default_nettype none

interface bce_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [bce_pkg::KEY_W-1:0]   key_index;
    logic [bce_pkg::NOW_W-1:0]   now_ms;

    modport source (output valid, output mode, output key_index, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input key_index, input now_ms,
                    output ready);
endinterface

interface bce_out_if;
    logic                          valid;
    logic                          ready;
    logic [bce_pkg::STATUS_W-1:0]  status;
    logic [bce_pkg::CHORD_W-1:0]   dot_mask;
    logic                          send_valid;
    logic [bce_pkg::BYTE_W-1:0]    send_byte;
    logic                          feedback_pulse;

    modport source (output valid, output status, output dot_mask, output send_valid,
                    output send_byte, output feedback_pulse, input ready);
    modport sink   (input valid, input status, input dot_mask, input send_valid,
                    input send_byte, input feedback_pulse, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bce_cfg.sv @@
// APB-style configuration registers: lockout window and key enable mask.
// Depends on bce_pkg.
`default_nettype none

module bce_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bce_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output bce_pkg::cfg_t                           cfg
);

    bce_pkg::cfg_t     cfg_reg;
    bce_pkg::reg_idx_t reg_sel;
    logic              wr_en;

    // Registers sit on 32-bit words, so the word index is the address bit above the byte lane.
    assign reg_sel = bce_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms      <= bce_pkg::LOCKOUT_RESET;
            cfg_reg.key_enable_mask <= bce_pkg::ENABLE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                bce_pkg::REG_LOCKOUT:
                    cfg_reg.lockout_ms <= pwdata[bce_pkg::LOCKOUT_W-1:0];
                bce_pkg::REG_ENABLE:
                    cfg_reg.key_enable_mask <= pwdata[bce_pkg::MASK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bce_pkg::REG_LOCKOUT:
                prdata = bce_pkg::APB_DATA_W'(cfg_reg.lockout_ms);
            bce_pkg::REG_ENABLE:
                prdata = bce_pkg::APB_DATA_W'(cfg_reg.key_enable_mask);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/braille_chord_key_encoder.sv @@
// Braille chord key encoder: each item goes into an input register, and its result is
// written to the output register when that is empty or its result is being taken.
// One item per cycle while result.ready stays high; the chord, and the per-key time table
// for an accepted key, are updated at the edge an item moves from input to output register.
// Reset (rst_n low, asynchronous) empties both stages and the chord, clears all stored
// key times to zero and restores the lockout (200) and enable mask (60) registers.
`default_nettype none

module braille_chord_key_encoder #(
    parameter int TIME_BITS = bce_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    bce_in_if.sink                                  key_evt,
    bce_out_if.source                               result,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bce_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    bce_pkg::cfg_t cfg;

    bce_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage.
    logic                         s1_valid_reg;
    bce_pkg::mode_t               s1_mode_reg;
    logic [bce_pkg::KEY_W-1:0]    s1_key_reg;
    logic [TIME_BITS-1:0]         s1_now_reg;

    // Encoder state.
    logic [bce_pkg::CHORD_W-1:0]  chord_reg;
    logic [TIME_BITS-1:0]         last_time_reg [bce_pkg::NUM_KEYS];

    // Output stage.
    logic                         out_valid_reg;
    bce_pkg::status_t             status_reg;
    logic [bce_pkg::CHORD_W-1:0]  dot_mask_reg;
    logic                         send_valid_reg;
    logic [bce_pkg::BYTE_W-1:0]   send_byte_reg;
    logic                         pulse_reg;

    logic                         advance;
    logic [bce_pkg::CHORD_W-1:0]  chord_next;
    bce_pkg::status_t             status_next;
    logic                         send_valid_next;
    logic [bce_pkg::BYTE_W-1:0]   send_byte_next;
    logic                         pulse_next;
    logic                         store_time;
    logic [TIME_BITS-1:0]         window_end;
    logic                         key_enabled;

    assign advance       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign key_evt.ready = !s1_valid_reg || advance;

    // The window end wraps at the time width, as the stored times do.
    assign window_end  = last_time_reg[s1_key_reg] + TIME_BITS'(cfg.lockout_ms);
    assign key_enabled = cfg.key_enable_mask[s1_key_reg];

    always_comb
    begin
        chord_next      = chord_reg;
        status_next     = bce_pkg::ST_DISABLED;
        send_valid_next = 1'b0;
        send_byte_next  = '0;
        pulse_next      = 1'b0;
        store_time      = 1'b0;

        if (s1_mode_reg == bce_pkg::MODE_CLEAR)
        begin
            chord_next  = '0;
            status_next = bce_pkg::ST_CMD_CLEAR;
        end
        else if (!key_enabled)
        begin
            status_next = bce_pkg::ST_DISABLED;
        end
        else if (s1_now_reg < window_end)
        begin
            status_next = bce_pkg::ST_BOUNCED;
        end
        else
        begin
            store_time = 1'b1;
            pulse_next = 1'b1;
            if (s1_key_reg == bce_pkg::KEY_DELETE)
            begin
                if (chord_reg != '0)
                begin
                    chord_next  = '0;
                    status_next = bce_pkg::ST_CLEARED;
                end
                else
                begin
                    send_valid_next = 1'b1;
                    send_byte_next  = bce_pkg::BYTE_ERASE;
                    status_next     = bce_pkg::ST_ERASE;
                end
            end
            else if (s1_key_reg == bce_pkg::KEY_ENTER)
            begin
                send_valid_next = 1'b1;
                if (chord_reg != '0)
                begin
                    send_byte_next = bce_pkg::BYTE_W'(chord_reg);
                    chord_next     = '0;
                    status_next    = bce_pkg::ST_CHAR;
                end
                else
                begin
                    send_byte_next = bce_pkg::BYTE_NEWLINE;
                    status_next    = bce_pkg::ST_NEWLINE;
                end
            end
            else
            begin
                chord_next  = chord_reg ^ (bce_pkg::CHORD_W'(1) << s1_key_reg);
                status_next = bce_pkg::ST_TOGGLED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chord_reg     <= '0;
            for (int k = 0; k < bce_pkg::NUM_KEYS; k++)
            begin
                last_time_reg[k] <= '0;
            end
        end
        else
        begin
            if (key_evt.ready)
            begin
                s1_valid_reg <= key_evt.valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                chord_reg     <= chord_next;
                if (store_time)
                begin
                    last_time_reg[s1_key_reg] <= s1_now_reg;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (key_evt.ready && key_evt.valid)
        begin
            s1_mode_reg <= bce_pkg::mode_t'(key_evt.mode);
            s1_key_reg  <= key_evt.key_index;
            // Timestamps are taken modulo the stored time width.
            s1_now_reg  <= TIME_BITS'(key_evt.now_ms);
        end
        if (advance)
        begin
            status_reg     <= status_next;
            dot_mask_reg   <= chord_next;
            send_valid_reg <= send_valid_next;
            send_byte_reg  <= send_byte_next;
            pulse_reg      <= pulse_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.dot_mask       = dot_mask_reg;
    assign result.send_valid     = send_valid_reg;
    assign result.send_byte      = send_byte_reg;
    assign result.feedback_pulse = pulse_reg;

`ifndef SYNTH
    // A waiting result always shows the chord as it stands, since the input stage
    // cannot move on until that result is taken.
    a_dot_mask_tracks_chord: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> dot_mask_reg == chord_reg)
        else $error("dot_mask differs from the chord state");

    a_no_byte_without_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !send_valid_reg |-> send_byte_reg == '0)
        else $error("send_byte nonzero while no byte is sent");

    a_pulse_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> pulse_reg == (status_reg != bce_pkg::ST_DISABLED &&
                                         status_reg != bce_pkg::ST_BOUNCED &&
                                         status_reg != bce_pkg::ST_CMD_CLEAR))
        else $error("feedback pulse inconsistent with status");

    a_chord_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == bce_pkg::ST_CHAR ||
                          status_reg == bce_pkg::ST_CLEARED ||
                          status_reg == bce_pkg::ST_CMD_CLEAR) |-> dot_mask_reg == '0)
        else $error("chord not empty after a clearing action");
`endif

endmodule

`default_nettype wire
